// ===== rtl/tdpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpf_pkg
// Shared types, step names and the microcode table of the trial division
// prime factorizer.
// ----------------------------------------------------------------------------
package tdpf_pkg;

  // Width of the value and factor fields on the channels
  localparam int unsigned FieldW = 32;
  // Step counter width and microcode depth
  localparam int unsigned PcW    = 4;

  // Datapath operation of one step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT_IN,
    OP_DIV,
    OP_STASH_CAND,
    OP_STASH_REM,
    OP_INC,
    OP_FLUSH,
    OP_EMPTY
  } op_e;

  // Jump condition, tested once the operation of the step completes
  typedef enum logic [2:0] {
    CC_NEVER,
    CC_ALWAYS,
    CC_LT2,
    CC_CAND_GT_Q,
    CC_R_NZ,
    CC_R_Z
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ucode_t;

  // Step addresses
  localparam logic [PcW-1:0] StepIdle      = 4'd0;
  localparam logic [PcW-1:0] StepCheck     = 4'd1;
  localparam logic [PcW-1:0] StepDiv       = 4'd2;
  localparam logic [PcW-1:0] StepBound     = 4'd3;
  localparam logic [PcW-1:0] StepTestRem   = 4'd4;
  localparam logic [PcW-1:0] StepFactor    = 4'd5;
  localparam logic [PcW-1:0] StepDivAgain  = 4'd6;
  localparam logic [PcW-1:0] StepTestAgain = 4'd7;
  localparam logic [PcW-1:0] StepNext      = 4'd8;
  localparam logic [PcW-1:0] StepTail      = 4'd9;
  localparam logic [PcW-1:0] StepStashRem  = 4'd10;
  localparam logic [PcW-1:0] StepFlush     = 4'd11;
  localparam logic [PcW-1:0] StepEmpty     = 4'd12;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic lt2;
    logic cand_gt_q;
    logic r_nz;
    logic div_done;
    logic pend_v;
    logic out_free;
  } status_t;

  // Actions from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic stash_cand;
    logic stash_rem;
    logic inc;
    logic flush;
    logic empty;
  } act_t;

  // Microcode program
  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      StepIdle:      w = '{OP_WAIT_IN,    CC_NEVER,     StepIdle};
      StepCheck:     w = '{OP_NOP,        CC_LT2,       StepEmpty};
      StepDiv:       w = '{OP_DIV,        CC_NEVER,     StepIdle};
      StepBound:     w = '{OP_NOP,        CC_CAND_GT_Q, StepTail};
      StepTestRem:   w = '{OP_NOP,        CC_R_NZ,      StepNext};
      StepFactor:    w = '{OP_STASH_CAND, CC_NEVER,     StepIdle};
      StepDivAgain:  w = '{OP_DIV,        CC_NEVER,     StepIdle};
      StepTestAgain: w = '{OP_NOP,        CC_R_Z,       StepFactor};
      StepNext:      w = '{OP_INC,        CC_ALWAYS,    StepDiv};
      StepTail:      w = '{OP_NOP,        CC_LT2,       StepFlush};
      StepStashRem:  w = '{OP_STASH_REM,  CC_NEVER,     StepIdle};
      StepFlush:     w = '{OP_FLUSH,      CC_ALWAYS,    StepIdle};
      StepEmpty:     w = '{OP_EMPTY,      CC_ALWAYS,    StepIdle};
      default:       w = '{OP_NOP,        CC_ALWAYS,    StepIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tdpf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpf_if
// Valid/ready channels of the factorizer: input value and result item.
// ----------------------------------------------------------------------------
interface tdpf_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdpf_pkg::FieldW-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdpf_out_if;
  logic                         valid;
  logic                         ready;
  logic [tdpf_pkg::FieldW-1:0]  factor;
  logic                         last;
  logic                         empty_res;

  modport source (output valid, output factor, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input factor, input last, input empty_res,
                  output ready);
endinterface

// ===== rtl/tdpf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpf_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    num_q, num_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    den_q, den_d;
  logic [W:0]      trial;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, num_q[W-1]} - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W);
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        num_d = {num_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], num_q[W-1]};
        num_d = {num_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control under reset; operands need none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/tdpf_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpf_seq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module tdpf_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdpf_pkg::status_t status_i,
  output tdpf_pkg::act_t    act_o
);

  logic [tdpf_pkg::PcW-1:0] pc_q, pc_d;
  logic                     run_q, run_d;
  tdpf_pkg::ucode_t         word;
  logic                     op_done;
  logic                     cond_true;

  assign word = tdpf_pkg::ucode_rom(pc_q);

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      tdpf_pkg::CC_NEVER:     cond_true = 1'b0;
      tdpf_pkg::CC_ALWAYS:    cond_true = 1'b1;
      tdpf_pkg::CC_LT2:       cond_true = status_i.lt2;
      tdpf_pkg::CC_CAND_GT_Q: cond_true = status_i.cand_gt_q;
      tdpf_pkg::CC_R_NZ:      cond_true = status_i.r_nz;
      tdpf_pkg::CC_R_Z:       cond_true = !status_i.r_nz;
      default:                cond_true = 1'b0;
    endcase
  end

  // Decode the operation, stall until it can complete
  always_comb begin
    act_o   = '0;
    op_done = 1'b1;
    run_d   = run_q;
    case (word.op)
      tdpf_pkg::OP_WAIT_IN: begin
        act_o.in_ready = 1'b1;
        op_done        = status_i.in_valid;
      end
      tdpf_pkg::OP_DIV: begin
        if (!run_q) begin
          act_o.div_start = 1'b1;
          run_d           = 1'b1;
          op_done         = 1'b0;
        end else begin
          op_done = status_i.div_done;
          if (status_i.div_done) begin
            run_d = 1'b0;
          end
        end
      end
      tdpf_pkg::OP_STASH_CAND: begin
        op_done          = !status_i.pend_v || status_i.out_free;
        act_o.stash_cand = op_done;
      end
      tdpf_pkg::OP_STASH_REM: begin
        op_done         = !status_i.pend_v || status_i.out_free;
        act_o.stash_rem = op_done;
      end
      tdpf_pkg::OP_INC: begin
        act_o.inc = 1'b1;
      end
      tdpf_pkg::OP_FLUSH: begin
        op_done     = status_i.out_free;
        act_o.flush = op_done;
      end
      tdpf_pkg::OP_EMPTY: begin
        op_done     = status_i.out_free;
        act_o.empty = op_done;
      end
      default: begin
        op_done = 1'b1;
      end
    endcase
  end

  // Advance or jump once the step completes
  always_comb begin
    pc_d = pc_q;
    if (op_done) begin
      pc_d = cond_true ? word.target : pc_q + tdpf_pkg::PcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= tdpf_pkg::StepIdle;
      run_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      run_q <= run_d;
    end
  end

endmodule

// ===== rtl/trial_division_prime_factors_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_factors_unit
// Prime factorizer by trial division under microcode control.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one unsigned value per item, masked to VALUE_WIDTH bits.
//   out_o returns the prime factors of that value in ascending order, with
//   repeats, one item each; the final item of a value has last set. Values
//   zero and one give a single item with factor 0, last and empty_res set.
//   One value is worked at a time: in_i.ready is high only while the
//   sequencer sits in its idle step.
// Work per value:
//   Each trial divisor costs one pass of the bit-serial divider (W bits, with
//   W = VALUE_WIDTH capped at 32) and three sequencer steps, so the run time
//   of a value grows with the largest divisor tried; a 32-bit prime tries
//   about 65536 divisors.
// Reset and stalls:
//   Reset returns the sequencer to idle and drops any result in flight.
//   A result waits in the output register while out_o.ready is low; the
//   sequencer holds one more factor aside and stalls only when it must
//   hand over a factor while the output register is still full.
// ----------------------------------------------------------------------------
module trial_division_prime_factors_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdpf_in_if.sink      in_i,
  tdpf_out_if.source   out_o
);

  localparam int unsigned FW = tdpf_pkg::FieldW;
  localparam int unsigned DW = (VALUE_WIDTH < FW) ? VALUE_WIDTH : FW;

  tdpf_pkg::status_t status;
  tdpf_pkg::act_t    act;

  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] cand_q, cand_d;
  logic [DW-1:0] pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  logic          out_v_q, out_v_d;
  logic [DW-1:0] out_fac_q, out_fac_d;
  logic          out_last_q, out_last_d;
  logic          out_empty_q, out_empty_d;
  logic          out_free;
  logic          div_busy;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [DW-1:0] div_r;

  tdpf_div #(
    .W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (act.div_start),
    .num_i   (rem_q),
    .den_i   (cand_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_q),
    .rem_o   (div_r)
  );

  tdpf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .act_o    (act)
  );

  assign out_free = !out_v_q || out_o.ready;

  // Report datapath status to the sequencer
  always_comb begin
    status.in_valid  = in_i.valid;
    status.lt2       = rem_q < DW'(2);
    status.cand_gt_q = cand_q > div_q;
    status.r_nz      = div_r != '0;
    status.div_done  = div_done;
    status.pend_v    = pend_v_q;
    status.out_free  = out_free;
  end

  // Working registers and the held-back factor
  always_comb begin
    rem_d       = rem_q;
    cand_d      = cand_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    out_v_d     = out_v_q && !out_o.ready;
    out_fac_d   = out_fac_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;

    if (act.in_ready && in_i.valid) begin
      rem_d    = in_i.value[DW-1:0];
      cand_d   = DW'(2);
      pend_v_d = 1'b0;
    end

    // Hand the held factor to the output when a new one arrives
    if ((act.stash_cand || act.stash_rem) && pend_v_q) begin
      out_v_d     = 1'b1;
      out_fac_d   = pend_q;
      out_last_d  = 1'b0;
      out_empty_d = 1'b0;
    end
    if (act.stash_cand) begin
      pend_d   = cand_q;
      pend_v_d = 1'b1;
      rem_d    = div_q;
    end
    if (act.stash_rem) begin
      pend_d   = rem_q;
      pend_v_d = 1'b1;
    end

    if (act.inc) begin
      cand_d = cand_q + DW'(1);
    end

    // Release the held factor as the final one
    if (act.flush) begin
      out_v_d     = 1'b1;
      out_fac_d   = pend_q;
      out_last_d  = 1'b1;
      out_empty_d = 1'b0;
      pend_v_d    = 1'b0;
    end

    if (act.empty) begin
      out_v_d     = 1'b1;
      out_fac_d   = '0;
      out_last_d  = 1'b1;
      out_empty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    cand_q      <= cand_d;
    pend_q      <= pend_d;
    out_fac_q   <= out_fac_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign in_i.ready      = act.in_ready;
  assign out_o.valid     = out_v_q;
  assign out_o.factor    = FW'(out_fac_q);
  assign out_o.last      = out_last_q;
  assign out_o.empty_res = out_empty_q;

`ifndef SYNTHESIS
  // An empty result is always a single, final item with factor zero
  a_empty_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.empty_res |-> out_o.last && out_o.factor == '0)
    else $error("empty result malformed");

  // A real factor is never below two
  a_factor_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.empty_res |-> out_o.factor >= FW'(2))
    else $error("factor below two");

  // No factor is held back while a new value is accepted
  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !pend_v_q)
    else $error("held factor left over at idle");

  // The divider is started only when free
  a_div_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // Trial divisors stay at two or more while a value is worked
  a_cand_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act.div_start |-> cand_q >= DW'(2))
    else $error("trial divisor below two");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trial division prime factorizer. A clocked
// driver feeds values from a queue, a behavioral factorizer predicts the
// factor list of every accepted value, and a clocked monitor checks each
// result field by field. Idle and stall phases, a long output hold-off and
// drain pauses on the input exercise the handshakes and the stall logic.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FieldW      = tdpf_pkg::FieldW;
  localparam int unsigned ValueW      = 32;
  localparam logic [FieldW-1:0] ValueMask = {FieldW{1'b1}} >> (FieldW - ValueW);
  localparam int unsigned NumRandom   = 78;
  // Cap on trial divisors for random full-width values keeps each value cheap
  localparam int unsigned SpanCap     = 700;
  // Long output hold-off, started once a given number of values got in
  localparam int unsigned HoldAt      = 10;
  localparam int unsigned HoldLen     = 600;
  localparam int unsigned IdleLimit   = 250000;
  localparam int unsigned DrainCycles = 100;

  // Traffic phases
  localparam int PhSteady   = 0;
  localparam int PhSrcIdle  = 1;
  localparam int PhSnkStall = 2;
  localparam int PhBoth     = 3;

  typedef struct packed {
    logic [FieldW-1:0] factor;
    logic              last;
    logic              empty_res;
  } factor_res_t;

  typedef struct {
    logic [FieldW-1:0] value;
    bit                drain;
  } offer_t;

  logic clk = 1'b0;
  logic rst_n;

  tdpf_in_if  in_ch ();
  tdpf_out_if out_ch ();

  trial_division_prime_factors_unit #(
    .VALUE_WIDTH(ValueW)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Free-running clock, 12 ns period
  always #6 clk = ~clk;

  offer_t        value_q[$];
  factor_res_t   factor_q[$];
  int unsigned   n_total;
  int unsigned   n_in_acc;
  int unsigned   n_exp_total;
  int unsigned   n_res_seen;
  int unsigned   n_empty_seen;
  int unsigned   longest_list = 0;
  int unsigned   n_err = 0;
  int unsigned   hold_cnt;
  bit            hold_done;
  int unsigned   idle_cnt;
  int            phase;
  int unsigned   small_primes [12] = '{2, 2, 3, 3, 5, 7, 11, 13, 17, 31, 61, 97};

  assign phase = (n_total == 0) ? PhSteady :
                 ((n_in_acc * 4 / n_total) > 3) ? PhBoth : int'(n_in_acc * 4 / n_total);

  // Factor a value by trial division; return the number of divisors tried.
  // With commit set, the factor list is appended to the expected results.
  function automatic int unsigned factorize(input logic [FieldW-1:0] raw, input bit commit,
                                            output int unsigned n_out);
    logic [FieldW-1:0] rem;
    logic [FieldW-1:0] cand;
    factor_res_t       list[$];
    factor_res_t       r;
    int unsigned       span;
    rem  = raw & ValueMask;
    span = 0;
    if (rem < 2) begin
      r.factor    = '0;
      r.last      = 1'b1;
      r.empty_res = 1'b1;
      list.insert(list.size(), r);
    end else begin
      for (cand = 2; cand <= rem / cand; cand++) begin
        span++;
        while (rem % cand == 0) begin
          rem         = rem / cand;
          r.factor    = cand;
          r.last      = 1'b0;
          r.empty_res = 1'b0;
          list.insert(list.size(), r);
        end
      end
      // Leftover above one is the largest prime factor
      if (rem > 1) begin
        r.factor    = rem;
        r.last      = 1'b0;
        r.empty_res = 1'b0;
        list.insert(list.size(), r);
      end
      list[list.size()-1].last = 1'b1;
    end
    n_out = list.size();
    if (commit) begin
      foreach (list[k]) factor_q.insert(factor_q.size(), list[k]);
    end
    return span;
  endfunction

  task automatic queue_value(input logic [FieldW-1:0] v, input bit drain);
    offer_t o;
    o.value = v;
    o.drain = drain;
    value_q.insert(value_q.size(), o);
  endtask

  task automatic note_mismatch(input string what, input logic [FieldW-1:0] got,
                               input logic [FieldW-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    n_err++;
  endtask

  // Driver: offer values, hold them until taken, predict on acceptance
  always @(posedge clk or negedge rst_n) begin : drive_values
    bit          took;
    int unsigned n_new;
    int unsigned owed;
    int unsigned idle_pct;
    offer_t      nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      n_in_acc    <= 0;
      n_exp_total <= 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      owed = n_exp_total;
      if (took) begin
        void'(factorize(in_ch.value, 1'b1, n_new));
        owed = owed + n_new;
        if (n_new > longest_list) longest_list = n_new;
        n_in_acc    <= n_in_acc + 1;
        n_exp_total <= owed;
      end
      idle_pct = (phase == PhSrcIdle) ? 69 : (phase == PhBoth) ? 25 : 0;
      if (in_ch.valid && !took) begin
        // hold the offered item until the block takes it
      end else if (value_q.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                   (!value_q[0].drain || owed == n_res_seen)) begin
        nxt = value_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.value <= nxt.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output hold-off: keep ready low for a long stretch, once
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_in_acc == HoldAt) begin
      hold_cnt  <= HoldLen;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk or negedge rst_n) begin : check_factors
    factor_res_t want;
    int unsigned stall_pct;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      n_res_seen   <= 0;
      n_empty_seen <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (factor_q.size() == 0) begin
          note_mismatch("unexpected result", out_ch.factor, '0);
        end else begin
          want = factor_q.pop_front();
          if (out_ch.factor !== want.factor) note_mismatch("factor", out_ch.factor, want.factor);
          if (out_ch.last !== want.last)
            note_mismatch("last", FieldW'(out_ch.last), FieldW'(want.last));
          if (out_ch.empty_res !== want.empty_res)
            note_mismatch("empty_res", FieldW'(out_ch.empty_res), FieldW'(want.empty_res));
        end
        if (out_ch.empty_res === 1'b1) n_empty_seen <= n_empty_seen + 1;
        n_res_seen <= n_res_seen + 1;
      end
      stall_pct = (phase == PhSnkStall) ? 69 : (phase == PhBoth) ? 25 : 0;
      out_ch.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt < IdleLimit) begin
      idle_cnt <= idle_cnt + 1;
    end else begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, IdleLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    logic [FieldW-1:0] v;
    longint unsigned   acc;
    int unsigned       p;
    int unsigned       tries;
    int unsigned       dummy;
    int unsigned       kind;
    rst_n   = 1'b0;
    n_total = 0;

    // Directed: no-factor values, square bounds, widest list, bit extremes
    queue_value(32'd0, 1'b0);
    queue_value(32'd1, 1'b0);
    queue_value(32'd2, 1'b0);
    queue_value(32'd3, 1'b0);
    queue_value(32'd4, 1'b0);
    queue_value(32'd9, 1'b0);
    queue_value(32'd25, 1'b0);
    queue_value(32'd49, 1'b0);
    queue_value(32'd12, 1'b0);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'hFFFF_0000, 1'b0);
    queue_value(32'hFFFF_FFFF, 1'b0);
    queue_value(32'hAAAA_AAAA, 1'b0);
    queue_value(32'h5555_5555, 1'b0);
    queue_value(32'h0000_FFFF, 1'b0);
    queue_value(32'h0001_0000, 1'b0);
    queue_value(32'd65521, 1'b1);
    queue_value(32'd63001, 1'b0);
    queue_value(32'd1042441, 1'b0);
    queue_value(32'd1040399, 1'b0);
    queue_value(32'd2000006, 1'b0);
    queue_value(32'd720720, 1'b0);

    // Random: shifted small values, smooth products, capped full-width values, values 0 to 3
    for (int i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        v = FieldW'($urandom_range(0, 4095)) << $urandom_range(0, 31);
      end else if (kind <= 6) begin
        acc = 1;
        repeat ($urandom_range(1, 14)) begin
          p = small_primes[$urandom_range(0, 11)];
          if (acc * p <= 64'hFFFF_FFFF) acc = acc * p;
        end
        v = acc[FieldW-1:0];
      end else if (kind <= 8) begin
        tries = 0;
        do begin
          v = $urandom;
          tries++;
        end while (factorize(v, 1'b0, dummy) > SpanCap && tries < 40);
        if (factorize(v, 1'b0, dummy) > SpanCap) v = v >> 16;
      end else begin
        v = $urandom_range(0, 3);
      end
      queue_value(v, (i % 25) == 0);
    end
    n_total = value_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all values to go in, then for every result to come out
    while (n_in_acc != n_total) @(posedge clk);
    while (n_res_seen != n_exp_total) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (factor_q.size() != 0) begin
      note_mismatch("results never arrived", FieldW'(factor_q.size()), '0);
    end
    $display("Factored %0d values into %0d results (%0d empty, longest list %0d),",
             n_in_acc, n_res_seen, n_empty_seen, longest_list);
    $display("under steady, idle, stall and hold-off traffic; %0d mismatches.", n_err);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
